### design/dbfe_pkg.sv
// Shared types and constants of the delta bit-packing frame encoder.
package dbfe_pkg;

   // Sample width in use; the sample field itself is always 16 bits wide
   localparam int SAMPLE_WIDTH = 16;
   localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_WIDTH) - 32'd1);

   // Packing limits of delta_bits
   localparam logic [4:0] DELTA_BITS_MIN   = 5'd1;
   localparam logic [4:0] DELTA_BITS_MAX   = 5'd16;
   localparam logic [4:0] DELTA_BITS_RESET = 5'd8;
   localparam logic [7:0] TAIL_BYTE_RESET  = 8'd0;

   // Configuration register indexes
   localparam logic CSR_DELTA_BITS = 1'b0;
   localparam logic CSR_TAIL_BYTE  = 1'b1;

   // Result slots of one job, sent lowest first
   localparam int SLOT_COUNT_ALL = 7;
   localparam logic [2:0] SLOT_BYTE0 = 3'd0;
   localparam logic [2:0] SLOT_BYTE1 = 3'd1;
   localparam logic [2:0] SLOT_ERROR = 3'd2;
   localparam logic [2:0] SLOT_FLUSH = 3'd3;
   localparam logic [2:0] SLOT_COUNT = 3'd4;
   localparam logic [2:0] SLOT_STAMP = 3'd5;
   localparam logic [2:0] SLOT_END   = 3'd6;

   // Job queue depth
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One job: the results one input sample causes
   typedef struct packed {
      logic [SLOT_COUNT_ALL-1:0] slots;
      logic [7:0]                byte0;
      logic [7:0]                byte1;
      logic [7:0]                flush;
      logic [7:0]                count;
      logic [7:0]                stamp;
   } job_type;

   // Configuration seen by the front and back
   typedef struct packed {
      logic [4:0] delta_bits;
      logic [7:0] tail_byte;
   } csr_type;

endpackage

### design/dbfe_front.sv
// Front end: accepts samples, tracks frame state and builds result jobs.
module dbfe_front import dbfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  csr_type     csr,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] sample, [23:16] frame_time
   input  logic        req_tlast,   // last_sample
   input  logic        q_full,
   output logic        push,
   output job_type     push_job
);

   logic [15:0] prev_ff, prev_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  bp_ff, bp_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  stamp_ff, stamp_in;
   logic        inside_ff, inside_in;
   logic        aborted_ff, aborted_in;

   logic        accept;
   logic [15:0] smp;
   logic [7:0]  ftime;
   logic [4:0]  nb;
   logic [16:0] diff;
   logic        bad;
   logic [23:0] packed_bits;
   logic [4:0]  total;
   logic [7:0]  acc_next;
   logic        err_seen;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign smp        = req_tdata[15:0] & SAMPLE_MASK;
   assign ftime      = req_tdata[23:16];

   // Clamp the delta width to its legal range
   always_comb begin
      if (csr.delta_bits < DELTA_BITS_MIN) begin
         nb = DELTA_BITS_MIN;
      end else if (csr.delta_bits > DELTA_BITS_MAX) begin
         nb = DELTA_BITS_MAX;
      end else begin
         nb = csr.delta_bits;
      end
   end

   // Delta, range check and packing into the bit accumulator
   assign diff        = {1'b0, smp} - {1'b0, prev_ff};
   assign bad         = diff[16] || ((diff[15:0] >> nb) != 16'd0);
   assign packed_bits = {16'd0, acc_ff} | ({8'd0, diff[15:0]} << bp_ff);
   assign total       = {2'd0, bp_ff} + nb;

   always_comb begin
      case (total[4:3])
         2'd0:    acc_next = packed_bits[7:0];
         2'd1:    acc_next = packed_bits[15:8];
         2'd2:    acc_next = packed_bits[23:16];
         default: acc_next = 8'd0;
      endcase
   end

   // Classify the sample and update frame state
   always_comb begin
      prev_in    = prev_ff;
      acc_in     = acc_ff;
      bp_in      = bp_ff;
      count_in   = count_ff;
      stamp_in   = stamp_ff;
      inside_in  = inside_ff;
      aborted_in = aborted_ff;
      push       = 1'b0;
      err_seen   = 1'b0;
      push_job   = '0;
      push_job.count = count_ff;
      push_job.stamp = stamp_ff;
      if (accept) begin
         if (!inside_ff) begin
            // first sample of a frame goes out whole
            prev_in        = smp;
            acc_in         = 8'd0;
            bp_in          = 3'd0;
            stamp_in       = ftime;
            inside_in      = 1'b1;
            aborted_in     = 1'b0;
            push           = 1'b1;
            push_job.byte0 = smp[7:0];
            push_job.byte1 = smp[15:8];
            push_job.stamp = ftime;
            push_job.slots[SLOT_BYTE0] = 1'b1;
            push_job.slots[SLOT_BYTE1] = 1'b1;
            if (req_tlast) begin
               push_job.slots[SLOT_COUNT] = 1'b1;
               push_job.slots[SLOT_STAMP] = 1'b1;
               push_job.slots[SLOT_END]   = 1'b1;
               count_in  = count_ff + 8'd1;
               inside_in = 1'b0;
            end
         end else if (aborted_ff) begin
            // swallow the rest of an aborted frame
            if (req_tlast) begin
               inside_in  = 1'b0;
               aborted_in = 1'b0;
            end
         end else if (bad) begin
            err_seen   = 1'b1;
            prev_in    = smp;
            acc_in     = 8'd0;
            bp_in      = 3'd0;
            push       = 1'b1;
            push_job.slots[SLOT_ERROR] = 1'b1;
            if (req_tlast) begin
               inside_in  = 1'b0;
               aborted_in = 1'b0;
            end else begin
               aborted_in = 1'b1;
            end
         end else begin
            prev_in        = smp;
            acc_in         = acc_next;
            bp_in          = total[2:0];
            push_job.byte0 = packed_bits[7:0];
            push_job.byte1 = packed_bits[15:8];
            push_job.flush = acc_next;
            push_job.slots[SLOT_BYTE0] = (total[4:3] != 2'd0);
            push_job.slots[SLOT_BYTE1] = total[4];
            if (req_tlast) begin
               push_job.slots[SLOT_FLUSH] = (total[2:0] != 3'd0);
               push_job.slots[SLOT_COUNT] = 1'b1;
               push_job.slots[SLOT_STAMP] = 1'b1;
               push_job.slots[SLOT_END]   = 1'b1;
               count_in  = count_ff + 8'd1;
               acc_in    = 8'd0;
               bp_in     = 3'd0;
               inside_in = 1'b0;
            end
            push = (push_job.slots != '0);
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         acc_ff     <= '0;
         bp_ff      <= '0;
         count_ff   <= '0;
         stamp_ff   <= '0;
         inside_ff  <= 1'b0;
         aborted_ff <= 1'b0;
      end else begin
         prev_ff    <= prev_in;
         acc_ff     <= acc_in;
         bp_ff      <= bp_in;
         count_ff   <= count_in;
         stamp_ff   <= stamp_in;
         inside_ff  <= inside_in;
         aborted_ff <= aborted_in;
      end
   end

   // An error on a non-final sample leaves the frame aborted
   a_err_aborts: assert property (@(posedge clock) disable iff (reset)
      (err_seen && !req_tlast) |=> (aborted_ff && inside_ff))
      else $error("error did not abort the frame");

   // No job is pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");

endmodule

### design/dbfe_queue.sv
// Short job queue between the front end and the result sequencer.
module dbfe_queue import dbfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   job_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_pop;

   assign empty  = (cnt_ff == '0);
   assign full   = (cnt_ff == QCNT_W'(QDEPTH));
   assign head   = slot_ff[rd_ff];
   assign do_pop = pop && !empty;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!push && do_pop) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Fill count never exceeds the depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

endmodule

### design/dbfe_back.sv
// Back end: walks each job's result slots and drives the output register.
module dbfe_back import dbfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  job_type    head,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [1:0] rsp_tuser    // [0] frame_end, [1] overflow_error
);

   logic [SLOT_COUNT_ALL-1:0] mask_ff, mask_in, mask_after;
   job_type                   job_ff, job_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      out_end_ff, out_end_in;
   logic                      out_err_ff, out_err_in;
   logic                      can_load;
   logic                      emit;
   logic [2:0]                idx;

   assign can_load   = !out_valid_ff || rsp_tready;
   assign emit       = can_load && (mask_ff != '0);
   assign mask_after = emit ? (mask_ff & (mask_ff - 1'b1)) : mask_ff;
   assign pop        = (mask_after == '0) && !q_empty;

   // Lowest pending slot
   always_comb begin
      idx = SLOT_BYTE0;
      for (int i = SLOT_COUNT_ALL - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = 3'(i);
         end
      end
   end

   // Result for the selected slot
   always_comb begin
      out_byte_in = out_byte_ff;
      out_end_in  = out_end_ff;
      out_err_in  = out_err_ff;
      if (emit) begin
         out_end_in = 1'b0;
         out_err_in = 1'b0;
         case (idx)
            SLOT_BYTE0: out_byte_in = job_ff.byte0;
            SLOT_BYTE1: out_byte_in = job_ff.byte1;
            SLOT_ERROR: begin
               out_byte_in = 8'd0;
               out_end_in  = 1'b1;
               out_err_in  = 1'b1;
            end
            SLOT_FLUSH: out_byte_in = job_ff.flush;
            SLOT_COUNT: out_byte_in = job_ff.count;
            SLOT_STAMP: out_byte_in = job_ff.stamp;
            SLOT_END: begin
               out_byte_in = csr.tail_byte;
               out_end_in  = 1'b1;
            end
            default: out_byte_in = 8'd0;
         endcase
      end
   end

   // Job loading and output valid
   always_comb begin
      mask_in = mask_after;
      job_in  = job_ff;
      if (pop) begin
         mask_in = head.slots;
         job_in  = head;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_err_ff, out_end_ff};

   // An error result always closes the frame
   a_err_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("error result without frame_end");

   // Every job taken from the queue has at least one result
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |=> (mask_ff != '0))
      else $error("empty job loaded");

   // A new job is only loaded once the current one is finished
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0 && !emit) |=> (mask_ff == $past(mask_ff)))
      else $error("pending results dropped");

endmodule

### design/delta_bitpack_frame_encoder.sv
// Top level of the delta bit-packing frame encoder: config registers and wiring.
// A sample's first result goes through the job queue, job register and output register.
// Throughput: one result per cycle from the back end's slot sequencer while rsp_tready
//   allows it; an ordinary sample causes at most 2 results, up to 6 on a frame end.
// The front end takes one sample per cycle while the 4-entry job queue has room.
// Synchronous active-high reset clears frame state, the queue and the output register;
//   delta_bits returns to 8 and the trailing frame byte to 0.
module delta_bitpack_frame_encoder import dbfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] sample, [23:16] frame_time
   input  logic        req_tlast,   // last_sample
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] frame_end, [1] overflow_error
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   csr_type csr_ff, csr_in;
   logic    push;
   job_type push_job;
   logic    pop;
   job_type head;
   logic    q_empty;
   logic    q_full;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELTA_BITS: csr_in.delta_bits = csr_data[4:0];
            CSR_TAIL_BYTE:  csr_in.tail_byte  = csr_data;
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.delta_bits <= DELTA_BITS_RESET;
         csr_ff.tail_byte  <= TAIL_BYTE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dbfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   dbfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dbfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/delta_bitpack_frame_encoder_tb.sv
// Self-checking testbench of the delta bit-packing frame encoder: stream stimulus and byte checks.
`timescale 1ns / 100ps

module delta_bitpack_frame_encoder_tb import dbfe_pkg::*;;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 48;

   // Tracks the encoder's frame state and the bytes it owes
   class frame_byte_tracker;
      typedef struct packed {
         logic [7:0] value;
         logic       fend;
         logic       err;
      } enc_byte_type;

      enc_byte_type bytes_due[$];
      int           mismatches;
      logic [4:0]   delta_bits;
      logic [7:0]   tail_byte;
      logic [15:0]  prev_sample;
      logic [7:0]   acc_bits;
      logic [2:0]   held_bits;
      logic [7:0]   frame_count;
      logic [7:0]   stamp;
      bit           in_frame;
      bit           aborted;

      function new();
         mismatches  = 0;
         delta_bits  = DELTA_BITS_RESET;
         tail_byte   = TAIL_BYTE_RESET;
         prev_sample = '0;
         acc_bits    = '0;
         held_bits   = '0;
         frame_count = '0;
         stamp       = '0;
         in_frame    = 1'b0;
         aborted     = 1'b0;
      endfunction

      function void set_reg(logic idx, logic [7:0] val);
         if (idx == CSR_DELTA_BITS)
            delta_bits = val[4:0];
         else
            tail_byte = val;
      endfunction

      // Width actually used for packing; zero and oversize settings saturate
      function int unsigned field_bits();
         if (delta_bits < DELTA_BITS_MIN)
            return DELTA_BITS_MIN;
         if (delta_bits > DELTA_BITS_MAX)
            return DELTA_BITS_MAX;
         return delta_bits;
      endfunction

      function void push(logic [7:0] value, logic fend, logic err);
         enc_byte_type b;
         b.value = value;
         b.fend  = fend;
         b.err   = err;
         bytes_due.push_back(b);
      endfunction

      // Trailer: partial byte, counter, stamp, end byte
      function void close_frame();
         if (held_bits != 0)
            push(acc_bits, 1'b0, 1'b0);
         push(frame_count, 1'b0, 1'b0);
         push(stamp, 1'b0, 1'b0);
         push(tail_byte, 1'b1, 1'b0);
         frame_count = frame_count + 8'd1;
         acc_bits    = '0;
         held_bits   = '0;
         in_frame    = 1'b0;
         aborted     = 1'b0;
      endfunction

      // Accepted sample transaction: append the bytes it causes
      function void take_sample(logic [15:0] raw, logic [7:0] t, logic last);
         logic [15:0] s;
         int unsigned nb, limit, delta, acc, total;
         s = raw & SAMPLE_MASK;
         if (!in_frame) begin
            stamp       = t;
            prev_sample = s;
            acc_bits    = '0;
            held_bits   = '0;
            aborted     = 1'b0;
            in_frame    = 1'b1;
            push(s[7:0], 1'b0, 1'b0);
            push(s[15:8], 1'b0, 1'b0);
            if (last)
               close_frame();
            return;
         end
         // swallowed until the frame's last sample
         if (aborted) begin
            if (last) begin
               in_frame = 1'b0;
               aborted  = 1'b0;
            end
            return;
         end
         nb    = field_bits();
         limit = (32'd1 << nb) - 32'd1;
         if (s < prev_sample || 32'(s - prev_sample) > limit) begin
            push(8'h00, 1'b1, 1'b1);
            acc_bits    = '0;
            held_bits   = '0;
            prev_sample = s;
            if (last)
               in_frame = 1'b0;
            else
               aborted = 1'b1;
            return;
         end
         delta       = 32'(s - prev_sample);
         prev_sample = s;
         acc         = 32'(acc_bits) | (delta << held_bits);
         total       = 32'(held_bits) + nb;
         while (total >= 8) begin
            push(acc[7:0], 1'b0, 1'b0);
            acc   = acc >> 8;
            total = total - 8;
         end
         acc_bits  = acc[7:0];
         held_bits = total[2:0];
         if (last)
            close_frame();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Accepted result transaction against the oldest byte due
      task check_byte(logic [7:0] value, logic fend, logic err);
         enc_byte_type b;
         if (bytes_due.size() == 0) begin
            report($sformatf("unexpected byte %h fend %b err %b", value, fend, err));
            return;
         end
         b = bytes_due.pop_front();
         if (value !== b.value)
            report($sformatf("out_byte %h, want %h", value, b.value));
         if (fend !== b.fend)
            report($sformatf("frame_end %b, want %b (byte %h)", fend, b.fend, b.value));
         if (err !== b.err)
            report($sformatf("overflow_error %b, want %b (byte %h)", err, b.err, b.value));
      endtask

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] sample, [23:16] frame_time
   logic        req_tlast = 1'b0; // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic [1:0]  rsp_tuser;        // [0] frame_end, [1] overflow_error
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;

   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic        rx_hold = 1'b0;

   frame_byte_tracker book = new();

   delta_bitpack_frame_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random back-pressure, long hold on request, byte check
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            book.check_byte(rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
         if (rx_hold)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog
   initial begin : watchdog
      int unsigned n;
      for (n = 0; n < CYCLE_LIMIT; n++)
         @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one sample; valid stays high after acceptance for a back-to-back follow-up
   task automatic send_sample(input logic [15:0] s, input logic [7:0] t, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, s};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      book.take_sample(s, t, last);
   endtask

   // Stop offering and let every owed byte, plus any swallowed sample, clear the pipe
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (book.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] bits_val, input logic [7:0] end_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_DELTA_BITS;
      csr_data  <= bits_val;
      do
         @(posedge clock);
      while (!csr_ready);
      book.set_reg(CSR_DELTA_BITS, bits_val);
      csr_index <= CSR_TAIL_BYTE;
      csr_data  <= end_val;
      do
         @(posedge clock);
      while (!csr_ready);
      book.set_reg(CSR_TAIL_BYTE, end_val);
      csr_valid <= 1'b0;
   endtask

   // Whole frames: mostly legal deltas with random content, some bad deltas and noise
   task automatic send_frames(input int min_items);
      int sent, len, k, pick;
      int unsigned lim, room, d;
      logic [15:0] s, prev;
      sent = 0;
      prev = '0;
      while (sent < min_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            lim  = (32'd1 << book.field_bits()) - 32'd1;
            pick = $urandom_range(99);
            if (k == 0)
               s = (pick < 35) ? 16'($urandom_range(255)) : 16'($urandom);
            else if (pick < 4 && prev != 0)
               s = 16'($urandom_range(32'(prev) - 1, 0));
            else if (pick < 8 && 32'(prev) + lim < 32'hFFFF)
               s = 16'($urandom_range(32'hFFFF, 32'(prev) + lim + 1));
            else if (pick < 10)
               s = 16'($urandom);
            else begin
               room = 32'hFFFF - 32'(prev);
               if (room > lim)
                  room = lim;
               if (pick < 22)
                  d = room;
               else if (pick < 30)
                  d = 0;
               else
                  d = $urandom_range(room);
               s = prev + 16'(d);
            end
            send_sample(s, 8'($urandom), k == len - 1);
            prev = s;
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] bits_set [PHASES];
      logic [7:0] end_set [PHASES];
      logic [7:0] bits_val;
      int phase;
      bits_set = '{8'd8, 8'd1, 8'd16, 8'd0, 8'hFF, 8'd3, 8'd13};
      end_set  = '{8'h00, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00, 8'h00};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct  = 29;
      rx_idle_pct <= 46;

      // Directed, reset settings (8-bit deltas, end byte zero)
      // single-sample frames at both sample extremes
      send_sample(16'h0000, 8'h00, 1'b1);
      send_sample(16'hFFFF, 8'hFF, 1'b1);
      // zero delta, delta at the limit, small deltas
      send_sample(16'h1234, 8'h81, 1'b0);
      send_sample(16'h1234, 8'h00, 1'b0);
      send_sample(16'h1333, 8'h11, 1'b0);
      send_sample(16'h1334, 8'h22, 1'b0);
      send_sample(16'h13B4, 8'h33, 1'b1);
      // delta one past the limit, then the rest of the frame is swallowed
      send_sample(16'h0100, 8'h42, 1'b0);
      send_sample(16'h0200, 8'h43, 1'b0);
      send_sample(16'h0201, 8'h44, 1'b0);
      send_sample(16'h0202, 8'h45, 1'b1);
      // negative delta, swallowed last sample
      send_sample(16'h8000, 8'h50, 1'b0);
      send_sample(16'h7FFF, 8'h51, 1'b0);
      send_sample(16'hFFFF, 8'h52, 1'b1);
      // bad delta on the last sample closes the frame at once
      send_sample(16'h0010, 8'h60, 1'b0);
      send_sample(16'h0020, 8'h61, 1'b0);
      send_sample(16'h0000, 8'h62, 1'b1);
      // frame right after, top sample with zero delta
      send_sample(16'hFFFF, 8'h7E, 1'b0);
      send_sample(16'hFFFF, 8'h7F, 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            drain_results();
            bits_val = (phase == 6) ? 8'($urandom_range(2, 15)) : bits_set[phase];
            configure(bits_val, (phase >= 4) ? 8'($urandom) : end_set[phase]);
         end
         if (phase < 3) begin
            tx_idle_pct  = 29;
            rx_idle_pct <= 46;
         end else if (phase < 5) begin
            tx_idle_pct  = 46;
            rx_idle_pct <= 29;
         end else begin
            tx_idle_pct  = 0;
            rx_idle_pct <= 0;
         end
         if (phase == 5) begin
            // receiver holds off long enough for the block to stall its input
            fork
               begin
                  rx_hold <= 1'b1;
                  repeat (300) @(posedge clock);
                  rx_hold <= 1'b0;
               end
               send_frames(ITEMS_PER_PHASE);
            join
         end else begin
            send_frames(ITEMS_PER_PHASE);
         end
      end

      req_tvalid <= 1'b0;
      while (book.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
